// ===== rtl/core/nds_pkg.sv =====
// Shared constants, codes and types for the near-duplicate string filter.
package nds_pkg;

   localparam int ENTRIES   = 32;
   localparam int MAX_LEN   = 32;

   localparam int CHAR_W    = 8;
   localparam int THR_W     = 8;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 5;
   localparam int COUNT_W   = 6;
   localparam int CSR_IDX_W = 2;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int POS_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int ELEN_W = $clog2(MAX_LEN + 1);
   localparam int LEN_W  = $clog2(MAX_LEN + 2);
   localparam int DEPTH  = ENTRIES * MAX_LEN;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = ELEN_W + THR_W;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_NUM = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_DEN = CSR_IDX_W'(1);

   localparam logic [THR_W-1:0] THRESH_NUM_RST = THR_W'(4);
   localparam logic [THR_W-1:0] THRESH_DEN_RST = THR_W'(5);

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_SIMILAR  = 2'd1,
      ST_FULL     = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_RECV,
      S_START,
      S_LOAD,
      S_SCAN,
      S_DRAIN,
      S_MUL,
      S_TEST,
      S_COPY,
      S_CDRAIN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       cand_write;
      logic       result_set;
      status_type result_status;
      logic       entry_clear;
      logic       entry_next;
      logic       load_entry;
      logic       scan_issue;
      logic       mul_load;
      logic       copy_start;
      logic       copy_issue;
      logic       commit;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic too_long;
      logic full;
      logic empty;
      logic scan_last;
      logic copy_last;
      logic similar;
      logic entry_last;
      logic out_free;
   } dp_stat_type;

endpackage

// ===== rtl/core/nds_if.sv =====
// Handshake channel interfaces for candidate words, results and register writes.
interface nds_req_if import nds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

interface nds_rsp_if import nds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]  slot;
   logic [COUNT_W-1:0] stored_count;

   modport source (output valid, output status, output slot, output stored_count,
                   input ready);
   modport sink (input valid, input status, input slot, input stored_count,
                 output ready);
endinterface

interface nds_csr_if import nds_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [THR_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/nds_ctrl.sv =====
// Sequencer for receiving a candidate, comparing it with stored entries and inserting it.
module nds_ctrl import nds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_RECV: begin
            if (req_valid && req_last) state_in = S_START;
         end
         S_START: begin
            if (stat.too_long || stat.full) state_in = S_DONE;
            else if (stat.empty) state_in = S_COPY;
            else state_in = S_LOAD;
         end
         S_LOAD:  state_in = S_SCAN;
         S_SCAN: begin
            if (stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_MUL;
         S_MUL:   state_in = S_TEST;
         S_TEST: begin
            if (stat.similar) state_in = S_DONE;
            else if (stat.entry_last) state_in = S_COPY;
            else state_in = S_LOAD;
         end
         S_COPY: begin
            if (stat.copy_last) state_in = S_CDRAIN;
         end
         S_CDRAIN: state_in = S_DONE;
         S_DONE: begin
            if (stat.out_free) state_in = S_RECV;
         end
         default: state_in = S_RECV;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.result_status = ST_INSERTED;
      req_ready = 1'b0;
      case (state_ff)
         S_RECV: begin
            req_ready = 1'b1;
            cmd.cand_write = req_valid;
         end
         S_START: begin
            if (stat.too_long) begin
               cmd.result_set = 1'b1;
               cmd.result_status = ST_TOO_LONG;
            end else if (stat.full) begin
               cmd.result_set = 1'b1;
               cmd.result_status = ST_FULL;
            end else if (stat.empty) begin
               cmd.copy_start = 1'b1;
            end else begin
               cmd.entry_clear = 1'b1;
            end
         end
         S_LOAD:  cmd.load_entry = 1'b1;
         S_SCAN:  cmd.scan_issue = 1'b1;
         S_DRAIN: cmd = cmd;
         S_MUL:   cmd.mul_load = 1'b1;
         S_TEST: begin
            if (stat.similar) begin
               cmd.result_set = 1'b1;
               cmd.result_status = ST_SIMILAR;
            end else if (stat.entry_last) begin
               cmd.copy_start = 1'b1;
            end else begin
               cmd.entry_next = 1'b1;
            end
         end
         S_COPY:   cmd.copy_issue = 1'b1;
         S_CDRAIN: cmd.commit = 1'b1;
         S_DONE:   cmd.out_load = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

// ===== rtl/core/nds_datapath.sv =====
// Candidate buffer, entry store, match counter, threshold test and result register.
module nds_datapath import nds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [THR_W-1:0]     csr_data,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [SLOT_W-1:0]    rsp_slot,
   output logic [COUNT_W-1:0]   rsp_stored_count
);

   logic [CHAR_W-1:0] string_store [DEPTH];
   logic [CHAR_W-1:0] cand_buf [MAX_LEN];
   logic [ELEN_W-1:0] entry_len [ENTRIES];

   logic [THR_W-1:0]   thresh_num_ff, thresh_num_in;
   logic [THR_W-1:0]   thresh_den_ff, thresh_den_in;
   logic [LEN_W-1:0]   cand_len_ff, cand_len_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [IDX_W-1:0]   entry_ff, entry_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   pos_d_ff;
   logic               pipe_valid_ff, pipe_valid_in;
   logic               pipe_copy_ff, pipe_copy_in;
   logic [ELEN_W-1:0]  shorter_ff, shorter_in;
   logic [ELEN_W-1:0]  longer_ff, longer_in;
   logic [ELEN_W-1:0]  matches_ff, matches_in;
   logic [PROD_W-1:0]  prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]  prod_b_ff, prod_b_in;
   logic [CHAR_W-1:0]  store_q_ff;
   logic [CHAR_W-1:0]  buf_q_ff;
   status_type         result_status_ff, result_status_in;
   logic [SLOT_W-1:0]  result_slot_ff, result_slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [ELEN_W-1:0] elen;
   logic [ELEN_W-1:0] clen;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              cand_room;

   assign elen      = entry_len[entry_ff];
   assign clen      = ELEN_W'(cand_len_ff);
   assign rd_addr   = ADDR_W'(entry_ff) * ADDR_W'(MAX_LEN) + ADDR_W'(pos_ff);
   assign wr_addr   = ADDR_W'(occ_ff) * ADDR_W'(MAX_LEN) + ADDR_W'(pos_d_ff);
   assign cand_room = cand_len_ff < LEN_W'(MAX_LEN);

   // Storage
   always_ff @(posedge clock) begin
      if (cmd.cand_write && cand_room) begin
         cand_buf[cand_len_ff[POS_W-1:0]] <= req_char_code;
      end
      buf_q_ff   <= cand_buf[pos_ff];
      store_q_ff <= string_store[rd_addr];
      if (pipe_valid_ff && pipe_copy_ff) begin
         string_store[wr_addr] <= buf_q_ff;
      end
      if (cmd.commit) begin
         entry_len[occ_ff[IDX_W-1:0]] <= clen;
      end
   end

   always_comb begin
      thresh_num_in = thresh_num_ff;
      thresh_den_in = thresh_den_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_THRESH_NUM: thresh_num_in = csr_data;
            CSR_THRESH_DEN: thresh_den_in = csr_data;
            default: thresh_num_in = thresh_num_ff;
         endcase
      end

      cand_len_in = cand_len_ff;
      if (cmd.cand_write) begin
         cand_len_in = cand_room ? cand_len_ff + LEN_W'(1) : LEN_W'(MAX_LEN + 1);
      end else if (cmd.out_load) begin
         cand_len_in = '0;
      end

      occ_in = cmd.commit ? occ_ff + CNT_W'(1) : occ_ff;

      entry_in = entry_ff;
      if (cmd.entry_clear) entry_in = '0;
      else if (cmd.entry_next) entry_in = entry_ff + IDX_W'(1);

      pos_in = pos_ff;
      if (cmd.load_entry || cmd.copy_start) pos_in = '0;
      else if (cmd.scan_issue || cmd.copy_issue) pos_in = pos_ff + POS_W'(1);

      pipe_valid_in = cmd.scan_issue || cmd.copy_issue;
      pipe_copy_in  = cmd.copy_issue;

      shorter_in = shorter_ff;
      longer_in  = longer_ff;
      if (cmd.load_entry) begin
         shorter_in = (elen < clen) ? elen : clen;
         longer_in  = (elen > clen) ? elen : clen;
      end

      matches_in = matches_ff;
      if (cmd.load_entry) begin
         matches_in = '0;
      end else if (pipe_valid_ff && !pipe_copy_ff && store_q_ff == buf_q_ff) begin
         matches_in = matches_ff + ELEN_W'(1);
      end

      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      if (cmd.mul_load) begin
         prod_a_in = PROD_W'(matches_ff) * PROD_W'(thresh_den_ff);
         prod_b_in = PROD_W'(thresh_num_ff) * PROD_W'(longer_ff);
      end

      result_status_in = result_status_ff;
      result_slot_in   = result_slot_ff;
      if (cmd.result_set) begin
         result_status_in = cmd.result_status;
         result_slot_in   = '0;
      end else if (cmd.commit) begin
         result_status_in = ST_INSERTED;
         result_slot_in   = SLOT_W'(occ_ff);
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result_status_ff;
         rsp_slot_in   = result_slot_ff;
         rsp_count_in  = COUNT_W'(occ_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_num_ff <= THRESH_NUM_RST;
         thresh_den_ff <= THRESH_DEN_RST;
         cand_len_ff   <= '0;
         occ_ff        <= '0;
         pipe_valid_ff <= 1'b0;
         pipe_copy_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         thresh_num_ff <= thresh_num_in;
         thresh_den_ff <= thresh_den_in;
         cand_len_ff   <= cand_len_in;
         occ_ff        <= occ_in;
         pipe_valid_ff <= pipe_valid_in;
         pipe_copy_ff  <= pipe_copy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff         <= entry_in;
      pos_ff           <= pos_in;
      pos_d_ff         <= pos_ff;
      shorter_ff       <= shorter_in;
      longer_ff        <= longer_in;
      matches_ff       <= matches_in;
      prod_a_ff        <= prod_a_in;
      prod_b_ff        <= prod_b_in;
      result_status_ff <= result_status_in;
      result_slot_ff   <= result_slot_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_count_ff     <= rsp_count_in;
   end

   always_comb begin
      stat.too_long   = cand_len_ff > LEN_W'(MAX_LEN);
      stat.full       = occ_ff >= CNT_W'(ENTRIES);
      stat.empty      = occ_ff == '0;
      stat.scan_last  = ELEN_W'(pos_ff) + ELEN_W'(1) == shorter_ff;
      stat.copy_last  = LEN_W'(pos_ff) + LEN_W'(1) == cand_len_ff;
      stat.similar    = prod_a_ff >= prod_b_ff;
      stat.entry_last = CNT_W'(entry_ff) + CNT_W'(1) == occ_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_stored_count = rsp_count_ff;

endmodule

// ===== rtl/core/near_duplicate_string_filter_top.sv =====
// Top level of the near-duplicate string filter: sequencer, datapath and channels.
// Characters are taken one per cycle while receiving; after the last character a result is
// produced: an insertion, a rejection at the first similar entry, or a refusal when the table
// is full or the candidate too long; one character is compared per cycle.
// A result waits in an output register while the next candidate's characters are taken.
// Synchronous reset empties the table, clears the candidate and restores ratio 4/5.
module near_duplicate_string_filter_top import nds_pkg::*; (
   input logic      clock,
   input logic      reset,
   nds_req_if.sink  req_chan,
   nds_rsp_if.source rsp_chan,
   nds_csr_if.sink  csr_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   nds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nds_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_chan.char_code),
      .csr_write        (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_slot         (rsp_chan.slot),
      .rsp_stored_count (rsp_chan.stored_count)
   );

endmodule
